/* sv/hcb_pkg.sv */
// ============================================================================
// hcb_pkg: shared types and constants for the Huffman code builder
// Default sizes and the controller-to-datapath command and status structs.
// ============================================================================
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 32;
    localparam int FREQ_BITS_DEF   = 16;
    localparam int SYM_W           = 8;
    localparam int IN_FREQ_W       = 16;
    localparam int CODE_W          = 31;
    localparam int LEN_W           = 5;

    // Datapath operation codes issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // store one leaf
        OP_HEAP_INIT,   // heap[i] = i, one entry per cycle
        OP_SIFT_START,  // begin sift-down at given position
        OP_TAKE_MIN,    // pop root, move last entry to root, start sift-down
        OP_SIFT_STEP,   // one sift-down step
        OP_MAKE_NODE,   // create internal node from the two taken minima
        OP_UP_STEP,     // one sift-up step
        OP_WALK_START,  // push root on the walk stack
        OP_WALK_STEP,   // pop one stack entry, expand or emit
        OP_CLEAR        // end of run: reset counters
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take_second;  // OP_TAKE_MIN: result goes to the second slot
    } cmd_t;

    typedef struct packed {
        logic sift_done;    // sift-down or sift-up finished
        logic init_done;    // heap init reached the symbol count
        logic heap_one;     // heap size is at most one
        logic walk_empty;   // walk stack empty
        logic out_busy;     // output register holds an untaken code
        logic heapify_done; // every parent position sifted
    } status_t;

endpackage

/* sv/hcb_datapath.sv */
// ============================================================================
// hcb_datapath: node pool, heap, walk stack and output register
// Each operation is one register-to-register step; the controller sequences
// them. Leaves and internal nodes live in separate arrays of MAX_SYMBOLS
// entries; a node id is a tag bit (1 = internal) over the array index.
// ============================================================================
module hcb_datapath #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hcb_pkg::cmd_t              cmd,
    output hcb_pkg::status_t           status,
    input  logic [hcb_pkg::SYM_W-1:0]  in_symbol,
    input  logic [hcb_pkg::IN_FREQ_W-1:0] in_frequency,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [hcb_pkg::SYM_W-1:0]  out_symbol,
    output logic [hcb_pkg::CODE_W-1:0] out_bits,
    output logic [hcb_pkg::LEN_W-1:0]  out_length,
    output logic                       out_last,
    output logic                       out_dropped
);
    localparam int HW    = $clog2(MAX_SYMBOLS);
    localparam int NW    = HW + 1;
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int FW    = FREQ_BITS + $clog2(MAX_SYMBOLS) + 1;

    logic [FW-1:0]             lfreq_mem [MAX_SYMBOLS];
    logic [FW-1:0]             ifreq_mem [MAX_SYMBOLS];
    logic [hcb_pkg::SYM_W-1:0] nsym_mem  [MAX_SYMBOLS];
    logic [NW-1:0]             left_mem  [MAX_SYMBOLS];
    logic [NW-1:0]             right_mem [MAX_SYMBOLS];
    logic [NW-1:0]             heap_mem  [MAX_SYMBOLS];
    // walk stack never holds more than tree height plus one entries
    logic [NW-1:0]             stk_node  [MAX_SYMBOLS];
    logic [HW-1:0]             stk_depth [MAX_SYMBOLS];
    logic [hcb_pkg::CODE_W-1:0] stk_code [MAX_SYMBOLS];

    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic [CW-1:0] hsize_reg;
    logic [HW-1:0] next_reg;     // next internal node index
    logic [HW-1:0] pos_reg;      // sift position / init index
    logic [HW-1:0] parent_reg;   // heapify parent counter
    logic          parent_done_reg;
    logic          sift_done_reg;
    logic [NW-1:0] min_a_reg;
    logic [NW-1:0] min_b_reg;
    logic [NW-1:0] up_node_reg;
    logic [CW-1:0] sp_reg;

    logic          valid_reg;
    logic [hcb_pkg::SYM_W-1:0]  sym_reg;
    logic [hcb_pkg::CODE_W-1:0] bits_reg;
    logic [hcb_pkg::LEN_W-1:0]  len_reg;
    logic          last_reg;
    logic          drop_reg;

    logic          load_ok;
    logic          stalled;
    logic          emit;
    // Sift-down candidate selection at pos_reg
    logic [CW:0]   l_idx, r_idx;
    logic [HW-1:0] best;
    logic [FW-1:0] best_f;
    // Sift-up parent
    logic [HW-1:0] up_parent;
    logic [FW-1:0] up_f;
    // Walk pop
    logic [CW-1:0] sp_m1;
    logic [NW-1:0] w_node;
    logic [HW-1:0] w_depth;
    logic [hcb_pkg::CODE_W-1:0] w_code;

    // Frequency of a node id
    function automatic logic [FW-1:0] freq_of(input logic [NW-1:0] id);
        return id[HW] ? ifreq_mem[id[HW-1:0]] : lfreq_mem[id[HW-1:0]];
    endfunction

    assign load_ok = count_reg < CW'(MAX_SYMBOLS);
    assign stalled = valid_reg && !out_ready;
    assign emit    = (cmd.op == hcb_pkg::OP_WALK_STEP) && !stalled && !w_node[HW];

    always_comb
    begin
        l_idx  = (CW+1)'({pos_reg, 1'b1});
        r_idx  = l_idx + (CW+1)'(1);
        best   = pos_reg;
        best_f = freq_of(heap_mem[pos_reg]);
        if (l_idx < (CW+1)'(hsize_reg)
            && freq_of(heap_mem[l_idx[HW-1:0]]) < best_f)
        begin
            best   = l_idx[HW-1:0];
            best_f = freq_of(heap_mem[l_idx[HW-1:0]]);
        end
        if (r_idx < (CW+1)'(hsize_reg)
            && freq_of(heap_mem[r_idx[HW-1:0]]) < best_f)
        begin
            best = r_idx[HW-1:0];
        end
        up_parent = HW'((pos_reg - HW'(1)) >> 1);
        up_f      = freq_of(heap_mem[up_parent]);
        sp_m1     = sp_reg - CW'(1);
        w_node    = stk_node[sp_m1[HW-1:0]];
        w_depth   = stk_depth[sp_m1[HW-1:0]];
        w_code    = stk_code[sp_m1[HW-1:0]];
    end

    assign status.sift_done    = sift_done_reg;
    assign status.init_done    = (CW'(pos_reg) + CW'(1) >= count_reg);
    assign status.heap_one     = hsize_reg <= CW'(1);
    assign status.walk_empty   = sp_reg == '0;
    assign status.out_busy     = stalled;
    assign status.heapify_done = parent_done_reg;

    // Memories (no reset: written before read)
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            hcb_pkg::OP_LOAD:
            begin
                if (load_ok)
                begin
                    nsym_mem[count_reg[HW-1:0]]  <= in_symbol;
                    lfreq_mem[count_reg[HW-1:0]] <=
                        FW'(in_frequency[FREQ_BITS > 16 ? 15 : FREQ_BITS-1:0]);
                end
            end
            hcb_pkg::OP_HEAP_INIT:
                heap_mem[pos_reg] <= {1'b0, pos_reg};
            hcb_pkg::OP_TAKE_MIN:
                heap_mem[0] <= heap_mem[HW'(hsize_reg - CW'(1))];
            hcb_pkg::OP_SIFT_STEP:
            begin
                if (best != pos_reg)
                begin
                    heap_mem[best]    <= heap_mem[pos_reg];
                    heap_mem[pos_reg] <= heap_mem[best];
                end
            end
            hcb_pkg::OP_MAKE_NODE:
            begin
                ifreq_mem[next_reg] <= freq_of(min_a_reg) + freq_of(min_b_reg);
                left_mem[next_reg]  <= min_a_reg;
                right_mem[next_reg] <= min_b_reg;
            end
            hcb_pkg::OP_UP_STEP:
            begin
                if (pos_reg != '0 && freq_of(up_node_reg) < up_f)
                    heap_mem[pos_reg] <= heap_mem[up_parent];
                else
                    heap_mem[pos_reg] <= up_node_reg;
            end
            hcb_pkg::OP_WALK_START:
            begin
                stk_node[0]  <= heap_mem[0];
                stk_depth[0] <= '0;
                stk_code[0]  <= '0;
            end
            hcb_pkg::OP_WALK_STEP:
            begin
                if (w_node[HW] && !stalled)
                begin
                    stk_node[sp_m1[HW-1:0]]  <= right_mem[w_node[HW-1:0]];
                    stk_depth[sp_m1[HW-1:0]] <= w_depth + HW'(1);
                    stk_code[sp_m1[HW-1:0]]  <= {w_code[hcb_pkg::CODE_W-2:0], 1'b1};
                    stk_node[sp_reg[HW-1:0]]  <= left_mem[w_node[HW-1:0]];
                    stk_depth[sp_reg[HW-1:0]] <= w_depth + HW'(1);
                    stk_code[sp_reg[HW-1:0]]  <= {w_code[hcb_pkg::CODE_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            hsize_reg       <= '0;
            next_reg        <= '0;
            pos_reg         <= '0;
            parent_reg      <= '0;
            parent_done_reg <= 1'b0;
            sift_done_reg   <= 1'b0;
            min_a_reg       <= '0;
            min_b_reg       <= '0;
            up_node_reg     <= '0;
            sp_reg          <= '0;
            valid_reg       <= 1'b0;
            sym_reg         <= '0;
            bits_reg        <= '0;
            len_reg         <= '0;
            last_reg        <= 1'b0;
            drop_reg        <= 1'b0;
        end
        else
        begin
            // Output register: load on a leaf, free when taken
            if (emit)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            unique case (cmd.op)
                hcb_pkg::OP_LOAD:
                begin
                    if (load_ok)
                        count_reg <= count_reg + CW'(1);
                    else
                        overflow_reg <= 1'b1;
                    pos_reg <= '0;
                end
                hcb_pkg::OP_HEAP_INIT:
                begin
                    pos_reg   <= pos_reg + HW'(1);
                    hsize_reg <= count_reg;
                    next_reg  <= '0;
                    // first parent to sift: (n-2)/2
                    if (count_reg >= CW'(2))
                    begin
                        parent_reg      <= HW'((count_reg - CW'(2)) >> 1);
                        parent_done_reg <= 1'b0;
                    end
                    else
                        parent_done_reg <= 1'b1;
                end
                hcb_pkg::OP_SIFT_START:
                begin
                    pos_reg       <= parent_reg;
                    sift_done_reg <= 1'b0;
                    if (parent_reg == '0)
                        parent_done_reg <= 1'b1;
                    else
                        parent_reg <= parent_reg - HW'(1);
                end
                hcb_pkg::OP_TAKE_MIN:
                begin
                    if (cmd.take_second)
                        min_b_reg <= heap_mem[0];
                    else
                        min_a_reg <= heap_mem[0];
                    hsize_reg     <= hsize_reg - CW'(1);
                    pos_reg       <= '0;
                    sift_done_reg <= 1'b0;
                end
                hcb_pkg::OP_SIFT_STEP:
                begin
                    if (best == pos_reg)
                        sift_done_reg <= 1'b1;
                    pos_reg <= best;
                end
                hcb_pkg::OP_MAKE_NODE:
                begin
                    up_node_reg   <= {1'b1, next_reg};
                    next_reg      <= next_reg + HW'(1);
                    pos_reg       <= HW'(hsize_reg);
                    hsize_reg     <= hsize_reg + CW'(1);
                    sift_done_reg <= 1'b0;
                end
                hcb_pkg::OP_UP_STEP:
                begin
                    if (pos_reg != '0 && freq_of(up_node_reg) < up_f)
                        pos_reg <= up_parent;
                    else
                        sift_done_reg <= 1'b1;
                end
                hcb_pkg::OP_WALK_START:
                begin
                    sp_reg <= CW'(1);
                end
                hcb_pkg::OP_WALK_STEP:
                begin
                    if (!stalled)
                    begin
                        if (!w_node[HW])
                        begin
                            sym_reg   <= nsym_mem[w_node[HW-1:0]];
                            bits_reg  <= w_code;
                            len_reg   <= hcb_pkg::LEN_W'(w_depth);
                            last_reg  <= (sp_m1 == '0);
                            drop_reg  <= overflow_reg;
                            sp_reg    <= sp_m1;
                        end
                        else
                            sp_reg <= sp_reg + CW'(1);
                    end
                end
                hcb_pkg::OP_CLEAR:
                begin
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid   = valid_reg;
    assign out_symbol  = sym_reg;
    assign out_bits    = bits_reg;
    assign out_length  = len_reg;
    assign out_last    = last_reg;
    assign out_dropped = drop_reg;

endmodule

/* sv/hcb_controller.sv */
// ============================================================================
// hcb_controller: sequencer for load, heapify, merge rounds and code walk
// Issues at most one datapath command per cycle and steps on datapath status.
// ============================================================================
module hcb_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  hcb_pkg::status_t status,
    output hcb_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_HPFY, S_HSIFT, S_TAKE_A, S_SIFT_A, S_TAKE_B,
        S_SIFT_B, S_MAKE, S_UP, S_WSTART, S_WALK, S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next       = state_reg;
        cmd.op           = hcb_pkg::OP_NONE;
        cmd.take_second  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.op = hcb_pkg::OP_LOAD;
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op = hcb_pkg::OP_HEAP_INIT;
                if (status.init_done)
                    state_next = S_HPFY;
            end
            S_HPFY:
            begin
                if (status.heapify_done)
                    state_next = status.heap_one ? S_WSTART : S_TAKE_A;
                else
                begin
                    cmd.op     = hcb_pkg::OP_SIFT_START;
                    state_next = S_HSIFT;
                end
            end
            S_HSIFT:
            begin
                if (status.sift_done)
                    state_next = S_HPFY;
                else
                    cmd.op = hcb_pkg::OP_SIFT_STEP;
            end
            S_TAKE_A:
            begin
                cmd.op     = hcb_pkg::OP_TAKE_MIN;
                state_next = S_SIFT_A;
            end
            S_SIFT_A:
            begin
                if (status.sift_done)
                    state_next = S_TAKE_B;
                else
                    cmd.op = hcb_pkg::OP_SIFT_STEP;
            end
            S_TAKE_B:
            begin
                cmd.op          = hcb_pkg::OP_TAKE_MIN;
                cmd.take_second = 1'b1;
                state_next      = S_SIFT_B;
            end
            S_SIFT_B:
            begin
                if (status.sift_done)
                    state_next = S_MAKE;
                else
                    cmd.op = hcb_pkg::OP_SIFT_STEP;
            end
            S_MAKE:
            begin
                cmd.op     = hcb_pkg::OP_MAKE_NODE;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (status.sift_done)
                    state_next = status.heap_one ? S_WSTART : S_TAKE_A;
                else
                    cmd.op = hcb_pkg::OP_UP_STEP;
            end
            S_WSTART:
            begin
                cmd.op     = hcb_pkg::OP_WALK_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // leave only once the final code has been taken
                if (status.walk_empty)
                begin
                    if (!status.out_busy)
                        state_next = S_CLEAR;
                end
                else
                    cmd.op = hcb_pkg::OP_WALK_STEP;
            end
            S_CLEAR:
            begin
                cmd.op     = hcb_pkg::OP_CLEAR;
                state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/huffman_code_builder.sv */
// ============================================================================
// huffman_code_builder: Huffman code construction from symbol frequencies
// Loads leaves, builds the tree with a min-heap and emits one code per leaf.
// ============================================================================
// Usage: symbols load at one per cycle; the item marked last_symbol starts
// the build, and no input is taken until every code of the set has been
// delivered. The build time is set by the heap steps: heapify and sift-down
// share one compare step, and sift-up has its own. The build runs heap init,
// then per heapify parent its swaps, then per merge round the swaps of two
// sift-downs and one sift-up, then a walk over every tree node (2N-1) that
// waits while the output is not taken.
// Items beyond MAX_SYMBOLS are dropped and reported on dropped_any.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hcb_pkg::SYM_W-1:0]     symbol,
    input  logic [hcb_pkg::IN_FREQ_W-1:0] frequency,
    input  logic                          last_symbol,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcb_pkg::SYM_W-1:0]     code_symbol,
    output logic [hcb_pkg::CODE_W-1:0]    code_bits,
    output logic [hcb_pkg::LEN_W-1:0]     code_length,
    output logic                          last_code,
    output logic                          dropped_any
);
    hcb_pkg::cmd_t    cmd;
    hcb_pkg::status_t status;

    hcb_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_symbol),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hcb_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .FREQ_BITS   (FREQ_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_symbol    (symbol),
        .in_frequency (frequency),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_symbol   (code_symbol),
        .out_bits     (code_bits),
        .out_length   (code_length),
        .out_last     (last_code),
        .out_dropped  (dropped_any)
    );

endmodule

/* sv/hcb_checker.sv */
// ============================================================================
// hcb_checker: port-level checks for the Huffman code builder
// Watches the top-level handshakes over time.
// ============================================================================
module hcb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic last_symbol,
    input logic out_valid,
    input logic out_ready,
    input logic last_code
);
    // No input taken while codes are pending
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a code is pending");

    // Last input transaction closes the input side
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_symbol) |=> !in_ready)
        else $error("input ready right after last symbol");

    // Stalled code stays valid and keeps its last_code flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(last_code))
        else $error("code dropped while stalled");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_symbol (last_symbol),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .last_code   (last_code)
);

/* dv/huffman_code_builder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_builder_test: self-checking bench for the Huffman code builder
// Drives symbol/frequency sets through the input channel and compares every
// emitted code against a behavioral tree builder kept in the bench.
// ----------------------------------------------------------------------------
module huffman_code_builder_test;

    localparam int NSYM      = hcb_pkg::MAX_SYMBOLS_DEF;
    localparam int SYM_W     = hcb_pkg::SYM_W;
    localparam int IN_FREQ_W = hcb_pkg::IN_FREQ_W;
    localparam int CODE_W    = hcb_pkg::CODE_W;
    localparam int LEN_W     = hcb_pkg::LEN_W;
    localparam int POOL  = 2 * NSYM - 1;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              drop;
    } code_t;

    typedef struct {
        logic [SYM_W-1:0]     sym;
        logic [IN_FREQ_W-1:0] freq;
        logic                 last;
        bit                   typed;   // expected code typed into the table
        code_t                code;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0;
    logic [SYM_W-1:0] symbol = '0;
    logic [IN_FREQ_W-1:0] frequency = '0;
    logic last_symbol = 1'b0;
    logic in_ready, out_valid;
    logic [SYM_W-1:0] code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0] code_length;
    logic last_code, dropped_any;

    huffman_code_builder u_top (.*);

    always #1 clk = ~clk;

    // Tree builder state
    logic [20:0] pool_freq [POOL];
    logic [SYM_W-1:0] pool_sym [POOL];
    int lchild [POOL], rchild [POOL];
    int heap [NSYM];
    int heap_len;
    int held;
    bit dropped;
    code_t expected_codes [$];

    int errors = 0, cycles = 0;
    bit quiet = 1'b0;     // no sender gaps or receiver idling
    bit hold_off = 1'b0;  // long receiver stall

    function automatic void sift_down(int p);
        int b, l, r, t;
        forever
        begin
            b = p; l = 2 * p + 1; r = 2 * p + 2;
            if (l < heap_len && pool_freq[heap[l]] < pool_freq[heap[b]]) b = l;
            if (r < heap_len && pool_freq[heap[r]] < pool_freq[heap[b]]) b = r;
            if (b == p) return;
            t = heap[b]; heap[b] = heap[p]; heap[p] = t;
            p = b;
        end
    endfunction

    function automatic int pop_min();
        int top;
        top = heap[0];
        heap[0] = heap[heap_len - 1];
        heap_len--;
        sift_down(0);
        return top;
    endfunction

    // Build the tree for the held set and queue its codes in walk order
    function automatic void build_codes();
        int n, nxt, a, b, i, sp, node;
        int stk [2*NSYM]; int dep [2*NSYM]; logic [63:0] cd [2*NSYM];
        code_t c;
        n = held; nxt = held;
        for (i = 0; i < n; i++) heap[i] = i;
        heap_len = n;
        for (i = n / 2 - 1; i >= 0; i--) sift_down(i);
        while (heap_len > 1)
        begin
            a = pop_min(); b = pop_min();
            pool_freq[nxt] = pool_freq[a] + pool_freq[b];
            lchild[nxt] = a; rchild[nxt] = b;
            i = heap_len; heap_len++;
            while (i != 0 && pool_freq[nxt] < pool_freq[heap[(i - 1) / 2]])
            begin
                heap[i] = heap[(i - 1) / 2];
                i = (i - 1) / 2;
            end
            heap[i] = nxt;
            nxt++;
        end
        stk[0] = pop_min(); dep[0] = 0; cd[0] = 0; sp = 1;
        while (sp > 0)
        begin
            sp--;
            node = stk[sp];
            if (node < n)
            begin
                c.sym = pool_sym[node]; c.bits = cd[sp][CODE_W-1:0];
                c.len = dep[sp][LEN_W-1:0]; c.last = 1'b0; c.drop = dropped;
                expected_codes.push_back(c);
            end
            else
            begin
                stk[sp+1] = lchild[node]; dep[sp+1] = dep[sp] + 1;
                cd[sp+1] = cd[sp] << 1;
                stk[sp] = rchild[node]; dep[sp] = dep[sp] + 1;
                cd[sp] = (cd[sp] << 1) | 64'd1;
                sp += 2;
            end
        end
        expected_codes[$].last = 1'b1;
    endfunction

    function automatic void accept_symbol(logic [SYM_W-1:0] s, logic [IN_FREQ_W-1:0] f,
                                          logic l);
        if (held < NSYM)
        begin
            pool_sym[held] = s; pool_freq[held] = {5'd0, f};
            held++;
        end
        else
            dropped = 1'b1;
        if (l)
        begin
            build_codes();
            held = 0; dropped = 1'b0;
        end
    endfunction

    task automatic send(logic [SYM_W-1:0] s, logic [IN_FREQ_W-1:0] f, logic l);
        while (!quiet && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; symbol <= s; frequency <= f; last_symbol <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        accept_symbol(s, f, l);
    endtask

    // Random set of n symbols; mostly full-range frequencies, some narrow for ties
    task automatic send_set(int n);
        bit narrow;
        narrow = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++)
            send(SYM_W'($urandom_range(255)),
                 IN_FREQ_W'(narrow ? $urandom_range(3) : $urandom_range(65535)),
                 i == n - 1);
    endtask

    // Receiver with random idling and an optional long stall
    always @(posedge clk)
    begin
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else out_ready <= quiet || ($urandom_range(99) >= 17);
    end

    // Code checker
    always @(posedge clk)
    begin
        code_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{code_symbol, code_bits, code_length, last_code, dropped_any};
            if (expected_codes.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected code transaction %p", got);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10) $display("code mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("huffman_code_builder regression: fail");
            $finish;
        end
    end

    row_t dir [$];

    function automatic void add_row(logic [SYM_W-1:0] s, logic [IN_FREQ_W-1:0] f,
                                    logic l, bit t = 0, code_t c = '0);
        row_t r;
        r.sym = s; r.freq = f; r.last = l; r.typed = t; r.code = c;
        dir.push_back(r);
    endfunction

    initial
    begin
        code_t lone;
        held = 0; dropped = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: single symbol (length 0) at both extremes
        lone = '{8'hff, '0, '0, 1'b1, 1'b0};
        add_row(8'hff, 16'hffff, 1'b1, 1'b1, lone);
        lone = '{8'h00, '0, '0, 1'b1, 1'b0};
        add_row(8'h00, 16'h0000, 1'b1, 1'b1, lone);
        // two symbols, zero and max frequency
        add_row(8'haa, 16'h0000, 1'b0);
        add_row(8'h55, 16'hffff, 1'b1);
        // equal frequencies and duplicate symbols
        for (int i = 0; i < 4; i++) add_row(8'h11, 16'd7, i == 3);
        // sum overflowing 16 bits
        for (int i = 0; i < 3; i++)
            add_row(SYM_W'(8'h80 + i), IN_FREQ_W'(16'hfffe + i), i == 2);
        // skewed frequencies give a deep chain
        for (int i = 0; i < 12; i++) add_row(SYM_W'(i), 16'd1 << i, i == 11);
        foreach (dir[k])
        begin
            send(dir[k].sym, dir[k].freq, dir[k].last);
            if (dir[k].typed && expected_codes.size() != 0 &&
                expected_codes[$] !== dir[k].code)
            begin
                errors++;
                $display("table entry %0d: predicted %p", k, expected_codes[$]);
            end
        end

        // Capacity overflow with last mark on a dropped item
        for (int i = 0; i < NSYM + 3; i++)
            send(SYM_W'($urandom_range(255)), IN_FREQ_W'($urandom_range(65535)),
                 i == NSYM + 2);

        // Long receiver stall while a full set is offered
        hold_off <= 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_set(NSYM);
        join

        // Random sets, a quiet stretch in the middle
        for (int k = 0; k < 9; k++)
        begin
            quiet = (k >= 4 && k < 7);
            send_set(k % 5 == 0 ? NSYM : $urandom_range(1, 14));
        end
        quiet = 1'b0;
        send_set(NSYM + $urandom_range(1, 4));
        in_valid <= 1'b0;

        while (expected_codes.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("huffman_code_builder regression: pass");
        else
            $display("huffman_code_builder regression: fail");
        $finish;
    end
endmodule
